/* hw/rtl/asa_pkg.sv */
package asa_pkg;

    // request codes
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    // configuration register indexes
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_POOL = 1'b1;

    localparam logic [31:0] BASE_RESET = 32'd0;
    localparam logic [24:0] POOL_RESET = 25'd65536;
    localparam logic [24:0] POOL_LIMIT = 25'd16777216;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NOMEM  = 2'd1,
        STAT_ZERO   = 2'd2,
        STAT_BADREL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } cnt_op_t;

    // one stack entry: adjustment below the aligned offset, and the offset
    typedef struct packed {
        logic [7:0]  adj;
        logic [23:0] off;
    } entry_t;

    // what one request does to the stack state
    typedef struct packed {
        logic [31:0] granted;
        status_t     status;
        logic [24:0] top_next;
        logic [24:0] used_next;
        cnt_op_t     cnt_op;
        logic        wr_en;
        entry_t      wr_entry;
    } dp_result_t;

endpackage

/* hw/rtl/asa_stack_mem.sv */
module asa_stack_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  asa_pkg::entry_t       wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output asa_pkg::entry_t       rdata
);

    asa_pkg::entry_t mem [DEPTH];
    asa_pkg::entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/asa_datapath.sv */
module asa_datapath #(
    parameter int HEADER_BYTES = 1
) (
    input  logic [1:0]          action,
    input  logic [23:0]         req_bytes,
    input  logic [2:0]          align_log2,
    input  logic [31:0]         rel_addr,
    input  logic [31:0]         base,
    input  logic [24:0]         pool,
    input  logic [24:0]         top,
    input  logic [24:0]         used,
    input  logic                cnt_full,
    input  logic                cnt_zero,
    input  asa_pkg::entry_t     top_entry,
    output asa_pkg::dp_result_t res
);

    localparam logic [8:0] HDR = 9'(HEADER_BYTES);

    logic [7:0]  mask;
    logic [31:0] top_addr;
    logic [7:0]  raw_adj;
    logic [8:0]  gap;
    logic [8:0]  adj;
    logic [24:0] pool_eff;
    logic [25:0] need;
    logic [25:0] aligned_off;
    logic [31:0] freed;
    logic        rel_match;

    // alignment adjustment, at least HDR bytes below the aligned address
    always_comb begin
        mask     = 8'((9'd1 << align_log2) - 9'd1);
        top_addr = base + {7'd0, top};
        raw_adj  = (8'd0 - top_addr[7:0]) & mask;
        gap      = HDR - {1'b0, raw_adj};
        if ({1'b0, raw_adj} < HDR) begin
            adj = {1'b0, raw_adj} + ((gap + {1'b0, mask}) & ~{1'b0, mask});
        end else begin
            adj = {1'b0, raw_adj};
        end
    end

    assign pool_eff    = (pool > asa_pkg::POOL_LIMIT) ? asa_pkg::POOL_LIMIT : pool;
    assign need        = {1'b0, used} + {17'd0, adj} + {2'd0, req_bytes};
    assign aligned_off = {1'b0, top} + {17'd0, adj};
    assign freed       = {7'd0, top} - {8'd0, top_entry.off} + {24'd0, top_entry.adj};
    assign rel_match   = (base + {8'd0, top_entry.off}) == rel_addr;

    always_comb begin
        res.granted        = '0;
        res.status         = asa_pkg::STAT_OK;
        res.top_next       = top;
        res.used_next      = used;
        res.cnt_op         = asa_pkg::CNT_HOLD;
        res.wr_en          = 1'b0;
        res.wr_entry.adj   = adj[7:0];
        res.wr_entry.off   = aligned_off[23:0];
        unique case (action)
            asa_pkg::ACT_ALLOC: begin
                if (req_bytes == '0) begin
                    res.status = asa_pkg::STAT_ZERO;
                end else if (cnt_full || (need > {1'b0, pool_eff})) begin
                    res.status = asa_pkg::STAT_NOMEM;
                end else begin
                    res.granted   = base + {6'd0, aligned_off};
                    res.top_next  = 25'(aligned_off + {2'd0, req_bytes});
                    res.used_next = need[24:0];
                    res.cnt_op    = asa_pkg::CNT_INC;
                    res.wr_en     = 1'b1;
                end
            end
            asa_pkg::ACT_RELEASE: begin
                if (cnt_zero || !rel_match) begin
                    res.status = asa_pkg::STAT_BADREL;
                end else begin
                    res.used_next = ({7'd0, used} >= freed) ? 25'({7'd0, used} - freed) : '0;
                    res.top_next  = (top_entry.off >= {16'd0, top_entry.adj})
                                  ? {1'b0, top_entry.off - {16'd0, top_entry.adj}} : '0;
                    res.cnt_op    = asa_pkg::CNT_DEC;
                end
            end
            asa_pkg::ACT_CLEAR: begin
                res.top_next  = '0;
                res.used_next = '0;
                res.cnt_op    = asa_pkg::CNT_CLEAR;
            end
            default: begin
                // unused code: no change
            end
        endcase
    end

endmodule

/* hw/rtl/aligned_stack_allocator.sv */
// Aligned bump-pointer stack allocator over a byte pool.
// Request channel (s_*): one word per request, action allocate, release or
// clear, with size, alignment (log2) and the address to release.
// Result channel (m_*): exactly one word per request, with the granted address
// (allocate only), status, bytes in use and live allocation count after it.
// Config channel (cfg_*): index 0 writes base_address, index 1 pool_bytes;
// always ready, write only while no request is in flight.
// Result word is registered when the request commits in S_EXEC, which waits
// while an earlier result is pending. Requests are taken only in S_IDLE, one at a
// time; the top entry is read from the stack RAM at accept and used in S_EXEC.
// Reset: top, used bytes and count go to zero, base to 0, pool to 65536.
// The stack RAM is not cleared; only entries below the count are ever used.
// Stall: a pending result holds on m_* until taken; one more request may be
// accepted meanwhile and waits, fully computed, until the output frees up.
module aligned_stack_allocator #(
    parameter int MAX_ALLOCATIONS = 256,
    parameter int HEADER_BYTES    = 1
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [23:0] s_request_bytes,
    input  logic [2:0]  s_alignment_log2,
    input  logic [31:0] s_release_address,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_granted_address,
    output logic [1:0]  m_status,
    output logic [24:0] m_used_bytes,
    output logic [8:0]  m_live_count,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_ALLOCATIONS + 1);
    localparam int IDX_W = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t      state_reg;

    // config registers
    logic [31:0] base_reg;
    logic [24:0] pool_reg;

    // stack state
    logic [24:0]      top_reg;
    logic [24:0]      used_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // captured request word
    logic [1:0]  act_reg;
    logic [23:0] size_reg;
    logic [2:0]  align_reg;
    logic [31:0] rel_reg;

    // result register
    logic        m_valid_reg;
    logic [31:0] granted_reg;
    logic [1:0]  status_reg;
    logic [24:0] used_out_reg;
    logic [8:0]  live_out_reg;

    logic                s_fire;
    logic                commit;
    asa_pkg::entry_t     top_entry;
    asa_pkg::dp_result_t dp;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign commit    = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;

    // Top entry is read at accept; the write of a commit always lands before
    // the next accept, which needs S_IDLE again, so no forwarding is needed.
    asa_stack_mem #(
        .DEPTH  (MAX_ALLOCATIONS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (commit && dp.wr_en),
        .waddr (IDX_W'(cnt_reg)),
        .wdata (dp.wr_entry),
        .re    (s_fire),
        .raddr (IDX_W'(cnt_reg - CNT_W'(1))),
        .rdata (top_entry)
    );

    asa_datapath #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .action     (act_reg),
        .req_bytes  (size_reg),
        .align_log2 (align_reg),
        .rel_addr   (rel_reg),
        .base       (base_reg),
        .pool       (pool_reg),
        .top        (top_reg),
        .used       (used_reg),
        .cnt_full   (cnt_reg >= CNT_W'(MAX_ALLOCATIONS)),
        .cnt_zero   (cnt_reg == '0),
        .top_entry  (top_entry),
        .res        (dp)
    );

    always_comb begin
        case (dp.cnt_op)
            asa_pkg::CNT_INC:   cnt_next = cnt_reg + CNT_W'(1);
            asa_pkg::CNT_DEC:   cnt_next = cnt_reg - CNT_W'(1);
            asa_pkg::CNT_CLEAR: cnt_next = '0;
            default:            cnt_next = cnt_reg;
        endcase
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= asa_pkg::BASE_RESET;
            pool_reg <= asa_pkg::POOL_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                asa_pkg::CFG_BASE: base_reg <= cfg_data;
                asa_pkg::CFG_POOL: pool_reg <= cfg_data[24:0];
                default:           base_reg <= base_reg;
            endcase
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act_reg   <= s_action;
            size_reg  <= s_request_bytes;
            align_reg <= s_alignment_log2;
            rel_reg   <= s_release_address;
        end
    end

    // sequencer, stack state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            top_reg     <= '0;
            used_reg    <= '0;
            cnt_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (commit) begin
                        top_reg      <= dp.top_next;
                        used_reg     <= dp.used_next;
                        cnt_reg      <= cnt_next;
                        m_valid_reg  <= 1'b1;
                        granted_reg  <= dp.granted;
                        status_reg   <= dp.status;
                        used_out_reg <= dp.used_next;
                        live_out_reg <= 9'(32'(cnt_next));
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_granted_address = granted_reg;
    assign m_status          = status_reg;
    assign m_used_bytes      = used_out_reg;
    assign m_live_count      = live_out_reg;

endmodule
